### design/postfix_stack_evaluator_defines.svh
// ----------------------------------------------------------------------------
// postfix stack evaluator assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_DEFINES_SVH

`ifndef SYNTH
`define PSE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PSE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSE_ASSERT(label, clk, rst, prop, msg)
`define PSE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### design/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// shared types and character codes of the postfix stack evaluator
// ----------------------------------------------------------------------------
package pse_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_POWER = 8'h24;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_POP
   } cell_op_type;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV,
      ALU_POW,
      ALU_BAD
   } alu_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_B,
      S_POP_A,
      S_CALC,
      S_WAIT,
      S_PUSH,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
      logic [7:0] a;
      logic [7:0] b;
   } alu_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic div0;
      logic bad;
   } alu_status_type;

   typedef struct packed {
      logic div0;
      logic bad;
      logic over;
      logic under;
   } flags_type;

endpackage

### design/pse_req_if.sv
// ----------------------------------------------------------------------------
// pse_req_if
// input character channel, one symbol per transfer
// ----------------------------------------------------------------------------
interface pse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);
endinterface

### design/pse_rsp_if.sv
// ----------------------------------------------------------------------------
// pse_rsp_if
// result channel, one value and sticky flags per transfer
// ----------------------------------------------------------------------------
interface pse_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] value;
   logic              divide_by_zero;
   logic              bad_symbol;
   logic              stack_overflow;
   logic              stack_underflow;

   modport source (output valid, output value, output divide_by_zero, output bad_symbol,
                   output stack_overflow, output stack_underflow, input ready);
   modport sink   (input valid, input value, input divide_by_zero, input bad_symbol,
                   input stack_overflow, input stack_underflow, output ready);
endinterface

### design/postfix_stack_evaluator.sv
// digit: PUSH after the transfer, then ready again; operator: POP_B, POP_A, CALC,
// then WAIT on the bit-serial divider (8 steps) or power unit (7 steps), then PUSH
// last item adds S_FINISH to load the result register, held while the prior result waits
// stack is a chain of shifting cells, one per entry, shifted once per push or pop
// reset (synchronous, active high) empties the stack and clears sticky flags
// no clearing pass: the store is never read above the fill count
`include "postfix_stack_evaluator_defines.svh"

// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// evaluates a postfix expression one character per transfer
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
   parameter int STACK_DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   pse_req_if.sink   req_chan,
   pse_rsp_if.source rsp_chan
);

   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

   pse_pkg::state_type state_ff, state_in;
   logic [7:0]        sym_ff, sym_in;
   logic              last_ff, last_in;
   logic [7:0]        opnd_a_ff, opnd_a_in;
   logic [7:0]        opnd_b_ff, opnd_b_in;
   logic [7:0]        result_ff, result_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   pse_pkg::flags_type flags_ff, flags_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_value_ff, rsp_value_in;
   pse_pkg::flags_type rsp_flags_ff, rsp_flags_in;

   pse_pkg::cell_op_type    cell_op;
   pse_pkg::alu_req_type    alu_req;
   pse_pkg::alu_status_type alu_status;
   pse_pkg::alu_op_type     alu_op;
   logic [7:0]              alu_result;
   logic [7:0]              cell_data [STACK_DEPTH];
   logic [7:0]              top_value;
   logic                    empty;
   logic                    full;
   logic                    req_xfer;
   logic                    is_digit;
   logic                    finish_go;

   assign empty     = (sp_ff == '0);
   assign full      = (sp_ff >= SP_FULL);
   assign top_value = empty ? 8'h00 : cell_data[0];
   assign req_xfer  = req_chan.valid && req_chan.ready;
   assign is_digit  = req_chan.symbol inside {[pse_pkg::CHAR_ZERO:pse_pkg::CHAR_NINE]};
   assign finish_go = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      case (sym_ff)
         pse_pkg::CHAR_PLUS:  alu_op = pse_pkg::ALU_ADD;
         pse_pkg::CHAR_MINUS: alu_op = pse_pkg::ALU_SUB;
         pse_pkg::CHAR_STAR:  alu_op = pse_pkg::ALU_MUL;
         pse_pkg::CHAR_SLASH: alu_op = pse_pkg::ALU_DIV;
         pse_pkg::CHAR_POWER: alu_op = pse_pkg::ALU_POW;
         default:             alu_op = pse_pkg::ALU_BAD;
      endcase
   end

   // stack cells
   genvar gi;
   generate
      for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
         logic [7:0] left_data;
         logic [7:0] right_data;
         if (gi == 0) begin : g_head
            assign left_data = result_ff;
         end else begin : g_body
            assign left_data = cell_data[gi-1];
         end
         if (gi == STACK_DEPTH - 1) begin : g_tail
            assign right_data = 8'h00;
         end else begin : g_next
            assign right_data = cell_data[gi+1];
         end
         pse_stack_cell u_cell (
            .clock      (clock),
            .op         (cell_op),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[gi])
         );
      end
   endgenerate

   pse_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .status (alu_status),
      .result (alu_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pse_pkg::S_IDLE: begin
            if (req_xfer) begin
               state_in = is_digit ? pse_pkg::S_PUSH : pse_pkg::S_POP_B;
            end
         end
         pse_pkg::S_POP_B: state_in = pse_pkg::S_POP_A;
         pse_pkg::S_POP_A: state_in = pse_pkg::S_CALC;
         pse_pkg::S_CALC:  state_in = pse_pkg::S_WAIT;
         pse_pkg::S_WAIT: begin
            if (alu_status.done) begin
               state_in = pse_pkg::S_PUSH;
            end
         end
         pse_pkg::S_PUSH: state_in = last_ff ? pse_pkg::S_FINISH : pse_pkg::S_IDLE;
         pse_pkg::S_FINISH: begin
            if (finish_go) begin
               state_in = pse_pkg::S_IDLE;
            end
         end
         default: state_in = pse_pkg::S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      sym_in        = sym_ff;
      last_in       = last_ff;
      opnd_a_in     = opnd_a_ff;
      opnd_b_in     = opnd_b_ff;
      result_in     = result_ff;
      sp_in         = sp_ff;
      flags_in      = flags_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_flags_in  = rsp_flags_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      cell_op       = pse_pkg::CELL_HOLD;
      alu_req.start = 1'b0;
      alu_req.op    = alu_op;
      alu_req.a     = opnd_a_ff;
      alu_req.b     = opnd_b_ff;
      req_chan.ready = 1'b0;
      case (state_ff)
         pse_pkg::S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               sym_in    = req_chan.symbol;
               last_in   = req_chan.last;
               result_in = req_chan.symbol - pse_pkg::CHAR_ZERO;
            end
         end
         pse_pkg::S_POP_B: begin
            opnd_b_in = top_value;
            if (empty) begin
               flags_in.under = 1'b1;
            end else begin
               cell_op = pse_pkg::CELL_POP;
               sp_in   = sp_ff - SP_W'(1);
            end
         end
         pse_pkg::S_POP_A: begin
            opnd_a_in = top_value;
            if (empty) begin
               flags_in.under = 1'b1;
            end else begin
               cell_op = pse_pkg::CELL_POP;
               sp_in   = sp_ff - SP_W'(1);
            end
         end
         pse_pkg::S_CALC: begin
            alu_req.start = 1'b1;
         end
         pse_pkg::S_WAIT: begin
            if (alu_status.done) begin
               result_in     = alu_result;
               flags_in.div0 = flags_ff.div0 | alu_status.div0;
               flags_in.bad  = flags_ff.bad | alu_status.bad;
            end
         end
         pse_pkg::S_PUSH: begin
            if (full) begin
               flags_in.over = 1'b1;
            end else begin
               cell_op = pse_pkg::CELL_PUSH;
               sp_in   = sp_ff + SP_W'(1);
            end
         end
         pse_pkg::S_FINISH: begin
            if (finish_go) begin
               rsp_valid_in       = 1'b1;
               rsp_value_in       = top_value;
               rsp_flags_in       = flags_ff;
               rsp_flags_in.under = flags_ff.under | empty;
               sp_in              = '0;
               flags_in           = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pse_pkg::S_IDLE;
         sp_ff        <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sym_ff       <= sym_in;
      last_ff      <= last_in;
      opnd_a_ff    <= opnd_a_in;
      opnd_b_ff    <= opnd_b_in;
      result_ff    <= result_in;
      rsp_value_ff <= rsp_value_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.value           = rsp_value_ff;
   assign rsp_chan.divide_by_zero  = rsp_flags_ff.div0;
   assign rsp_chan.bad_symbol      = rsp_flags_ff.bad;
   assign rsp_chan.stack_overflow  = rsp_flags_ff.over;
   assign rsp_chan.stack_underflow = rsp_flags_ff.under;

   `PSE_ASSERT(a_sp_bound, clock, reset, sp_ff <= SP_FULL, "fill count above stack depth")
   `PSE_ASSERT(a_push_room, clock, reset,
      (cell_op == pse_pkg::CELL_PUSH) |-> !full, "push into full stack")
   `PSE_ASSERT(a_pop_data, clock, reset,
      (cell_op == pse_pkg::CELL_POP) |-> !empty, "pop from empty stack")
   `PSE_ASSERT(a_alu_idle, clock, reset,
      alu_req.start |-> !alu_status.busy, "operator unit started while busy")
   `PSE_ASSERT(a_finish_clear, clock, reset,
      (state_ff == pse_pkg::S_FINISH && finish_go) |=>
      (sp_ff == '0 && flags_ff == '0 && rsp_valid_ff), "stack not emptied after result")

endmodule

### design/pse_stack_cell.sv
// ----------------------------------------------------------------------------
// pse_stack_cell
// one entry of the shifting stack, takes its left or right neighbor
// ----------------------------------------------------------------------------
module pse_stack_cell (
   input  logic                 clock,
   input  pse_pkg::cell_op_type op,
   input  logic [7:0]           left_data,
   input  logic [7:0]           right_data,
   output logic [7:0]           data
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   always_comb begin
      case (op)
         pse_pkg::CELL_PUSH: data_in = left_data;
         pse_pkg::CELL_POP:  data_in = right_data;
         default:            data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

### design/pse_alu.sv
// ----------------------------------------------------------------------------
// pse_alu
// operator unit, one-step add/sub/mul, bit-serial divide and power
// ----------------------------------------------------------------------------
module pse_alu (
   input  logic                    clock,
   input  logic                    reset,
   input  pse_pkg::alu_req_type    req,
   output pse_pkg::alu_status_type status,
   output logic [7:0]              result
);

   pse_pkg::alu_op_type op_ff, op_in;
   logic [7:0]  acc_ff, acc_in;
   logic [7:0]  base_ff, base_in;
   logic [7:0]  quo_ff, quo_in;
   logic [7:0]  rem_ff, rem_in;
   logic        neg_ff, neg_in;
   logic [2:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        div0_ff, div0_in;
   logic        bad_ff, bad_in;

   logic [15:0] sum_prod;
   logic [15:0] acc_prod;
   logic [15:0] sq_prod;
   logic [8:0]  rem_shift;
   logic [7:0]  abs_a;
   logic [7:0]  abs_b;
   logic [7:0]  div_res;

   assign sum_prod  = {8'h00, req.a} * {8'h00, req.b};
   assign acc_prod  = {8'h00, acc_ff} * {8'h00, base_ff};
   assign sq_prod   = {8'h00, base_ff} * {8'h00, base_ff};
   assign rem_shift = {rem_ff, quo_ff[7]};
   assign abs_a     = req.a[7] ? (8'h00 - req.a) : req.a;
   assign abs_b     = req.b[7] ? (8'h00 - req.b) : req.b;
   assign div_res   = neg_ff ? (8'h00 - quo_ff) : quo_ff;

   always_comb begin
      op_in    = op_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      div0_in  = div0_ff;
      bad_in   = bad_ff;
      if (req.start) begin
         op_in   = req.op;
         div0_in = 1'b0;
         bad_in  = 1'b0;
         done_in = 1'b1;
         case (req.op)
            pse_pkg::ALU_ADD: acc_in = req.a + req.b;
            pse_pkg::ALU_SUB: acc_in = req.a - req.b;
            pse_pkg::ALU_MUL: acc_in = sum_prod[7:0];
            pse_pkg::ALU_DIV: begin
               if (req.b == 8'h00) begin
                  acc_in  = 8'h00;
                  div0_in = 1'b1;
               end else begin
                  quo_in   = abs_a;
                  base_in  = abs_b;
                  rem_in   = 8'h00;
                  neg_in   = req.a[7] ^ req.b[7];
                  count_in = 3'd7;
                  busy_in  = 1'b1;
                  done_in  = 1'b0;
               end
            end
            pse_pkg::ALU_POW: begin
               if (req.b[7]) begin
                  if (req.a == 8'h01) begin
                     acc_in = 8'h01;
                  end else if (req.a == 8'hFF) begin
                     acc_in = req.b[0] ? 8'hFF : 8'h01;
                  end else begin
                     acc_in = 8'h00;
                  end
               end else begin
                  acc_in   = 8'h01;
                  base_in  = req.a;
                  quo_in   = req.b;
                  count_in = 3'd6;
                  busy_in  = 1'b1;
                  done_in  = 1'b0;
               end
            end
            default: begin
               acc_in = 8'h00;
               bad_in = 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         if (op_ff == pse_pkg::ALU_DIV) begin
            if (rem_shift >= {1'b0, base_ff}) begin
               rem_in = 8'(rem_shift - {1'b0, base_ff});
               quo_in = {quo_ff[6:0], 1'b1};
            end else begin
               rem_in = rem_shift[7:0];
               quo_in = {quo_ff[6:0], 1'b0};
            end
         end else begin
            if (quo_ff[0]) begin
               acc_in = acc_prod[7:0];
            end
            base_in = sq_prod[7:0];
            quo_in  = {1'b0, quo_ff[7:1]};
         end
         if (count_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff    <= op_in;
      acc_ff   <= acc_in;
      base_ff  <= base_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      count_ff <= count_in;
      div0_ff  <= div0_in;
      bad_ff   <= bad_in;
   end

   assign result = (op_ff == pse_pkg::ALU_DIV && !div0_ff) ? div_res : acc_ff;

   always_comb begin
      status.busy = busy_ff;
      status.done = done_ff;
      status.div0 = div0_ff;
      status.bad  = bad_ff;
   end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// streams postfix characters into the evaluator and checks every emitted
// value and flag set against an in-bench stack predictor; directed corner
// expressions first, then random expressions, noise and deep stacks under
// three idle profiles
// ----------------------------------------------------------------------------
module tb;

   localparam int STACK_DEPTH     = 64;
   localparam int PERIOD          = 20;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int ITEMS_PER_PHASE = 500;
   localparam int DRAIN_CYCLES    = 40;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
   } char_item_type;

   typedef struct packed {
      logic signed [7:0]  value;
      pse_pkg::flags_type flags;
   } evaluation_type;

   logic clock;
   logic reset;

   pse_req_if req_if ();
   pse_rsp_if rsp_if ();

   postfix_stack_evaluator #(
      .STACK_DEPTH(STACK_DEPTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   char_item_type  pending_chars[$];
   evaluation_type expected_results[$];

   logic [7:0]         model_stack[STACK_DEPTH];
   int unsigned        model_depth;
   pse_pkg::flags_type model_flags;

   int send_idle_pct;
   int recv_idle_pct;
   int fail_count;
   int queued_count;

   initial begin
      clock = 1'b0;
      forever #(PERIOD / 2) clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(CYCLE_LIMIT * PERIOD);
      $display("tb: FAIL");
      $finish;
   end

   // stack predictor

   function automatic void push_operand(logic [7:0] v);
      if (model_depth >= STACK_DEPTH) begin
         model_flags.over = 1'b1;
      end else begin
         model_stack[model_depth] = v;
         model_depth++;
      end
   endfunction

   function automatic int pop_operand();
      if (model_depth == 0) begin
         model_flags.under = 1'b1;
         return 0;
      end
      model_depth--;
      return int'($signed(model_stack[model_depth]));
   endfunction

   function automatic logic [7:0] raise_power(int base, int expo);
      logic [7:0] acc;
      logic [7:0] sq;
      int         e;
      if (expo < 0) begin
         if (base == 1) return 8'h01;
         if (base == -1) return (expo & 1) ? 8'hFF : 8'h01;
         return 8'h00;
      end
      acc = 8'h01;
      sq  = base[7:0];
      e   = expo;
      while (e != 0) begin
         if (e & 1) acc = acc * sq;
         sq = sq * sq;
         e  = e >> 1;
      end
      return acc;
   endfunction

   function automatic logic [7:0] apply_operator(logic [7:0] sym, int a, int b);
      int r;
      case (sym)
         pse_pkg::CHAR_PLUS:  r = a + b;
         pse_pkg::CHAR_MINUS: r = a - b;
         pse_pkg::CHAR_STAR:  r = a * b;
         pse_pkg::CHAR_SLASH: begin
            if (b == 0) begin
               model_flags.div0 = 1'b1;
               r = 0;
            end else begin
               r = a / b;
            end
         end
         pse_pkg::CHAR_POWER: r = int'(raise_power(a, b));
         default: begin
            model_flags.bad = 1'b1;
            r = 0;
         end
      endcase
      return r[7:0];
   endfunction

   function automatic bit evaluate_symbol(input char_item_type item,
                                          output evaluation_type res);
      int second;
      int first;
      int top;
      res = '0;
      if (item.symbol inside {[pse_pkg::CHAR_ZERO:pse_pkg::CHAR_NINE]}) begin
         push_operand(item.symbol - pse_pkg::CHAR_ZERO);
      end else begin
         second = pop_operand();
         first  = pop_operand();
         push_operand(apply_operator(item.symbol, first, second));
      end
      if (!item.last) return 1'b0;
      top         = pop_operand();
      res.value   = top[7:0];
      res.flags   = model_flags;
      model_depth = 0;
      model_flags = '0;
      return 1'b1;
   endfunction

   // driver and receiver

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.valid  <= 1'b1;
            req_if.symbol <= pending_chars[0].symbol;
            req_if.last   <= pending_chars[0].last;
            void'(pending_chars.pop_front());
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor

   task automatic check_field(string name, logic signed [31:0] want,
                              logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      char_item_type  seen;
      evaluation_type predicted;
      evaluation_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            seen.symbol = req_if.symbol;
            seen.last   = req_if.last;
            if (evaluate_symbol(seen, predicted)) expected_results.push_back(predicted);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with none expected, value %0d", rsp_if.value);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("value", 32'(want.value), 32'(rsp_if.value));
               check_field("divide_by_zero", 32'(want.flags.div0),
                           32'(rsp_if.divide_by_zero));
               check_field("bad_symbol", 32'(want.flags.bad), 32'(rsp_if.bad_symbol));
               check_field("stack_overflow", 32'(want.flags.over),
                           32'(rsp_if.stack_overflow));
               check_field("stack_underflow", 32'(want.flags.under),
                           32'(rsp_if.stack_underflow));
            end
         end
      end
   end

   // stimulus

   task automatic push_char(logic [7:0] sym, logic last);
      char_item_type item;
      item.symbol = sym;
      item.last   = last;
      pending_chars.push_back(item);
      queued_count++;
   endtask

   task automatic add_string(string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] pick_operator();
      case ($urandom_range(4))
         0:       return pse_pkg::CHAR_PLUS;
         1:       return pse_pkg::CHAR_MINUS;
         2:       return pse_pkg::CHAR_STAR;
         3:       return pse_pkg::CHAR_SLASH;
         default: return pse_pkg::CHAR_POWER;
      endcase
   endfunction

   task automatic add_expression();
      logic [7:0] syms[$];
      int         depth;
      int         target;
      int         cap;
      target = $urandom_range(1, 14);
      cap    = $urandom_range(2, 8);
      depth  = 0;
      while (syms.size() < target || depth > 1) begin
         if (depth < 2 || (syms.size() < target && depth < cap && $urandom_range(1) == 1)) begin
            syms.push_back(8'(pse_pkg::CHAR_ZERO + $urandom_range(9)));
            depth++;
         end else begin
            syms.push_back(pick_operator());
            depth--;
         end
      end
      for (int i = 0; i < syms.size(); i++) push_char(syms[i], i == syms.size() - 1);
   endtask

   task automatic add_noise();
      int n;
      n = $urandom_range(1, 4);
      repeat (n) push_char(8'($urandom_range(255)), $urandom_range(3) == 0);
   endtask

   // fills the stack to around its depth, then a few operators
   task automatic add_deep_stack(int pushes);
      int ops;
      ops = $urandom_range(3);
      for (int i = 0; i < pushes; i++) begin
         push_char(8'(pse_pkg::CHAR_ZERO + $urandom_range(9)), ops == 0 && i == pushes - 1);
      end
      for (int i = 0; i < ops; i++) push_char(pick_operator(), i == ops - 1);
   endtask

   task automatic wait_drained();
      while (pending_chars.size() != 0 || req_if.valid || expected_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      int phase_start;
      int pick;
      send_idle_pct = 29;
      recv_idle_pct = 85;
      fail_count    = 0;
      queued_count  = 0;
      model_depth   = 0;
      model_flags   = '0;
      @(negedge clock);
      while (reset) @(negedge clock);

      // empty pop, product, divide by zero, -128 / -1, 0 to the 0,
      // negative exponents, unknown characters at both extremes
      add_string("+");
      add_string("99*");
      add_string("50/");
      add_string("27$01-/");
      add_string("00$");
      add_string("101-$");
      add_string("901-$");
      push_char(8'hFF, 1'b1);
      push_char(8'h00, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 29;
               recv_idle_pct = 85;
            end
            1: begin
               send_idle_pct = 85;
               recv_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_start = queued_count;
         add_deep_stack(STACK_DEPTH + $urandom_range(1, 6));
         while (queued_count - phase_start < ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 85) add_expression();
            else if (pick < 97) add_noise();
            else add_deep_stack($urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 1));
         end
         // hold the sender until every result is back
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
